[rtl/sfes_pkg.sv]
`timescale 1ns / 1ps

package sfes_pkg;

	localparam int TIME_BITS = 24;
	localparam int ACC_BITS  = 32;
	localparam int VOL_BITS  = 7;
	localparam int QUO_BITS  = 7;
	localparam int PROD_BITS = TIME_BITS + VOL_BITS;
	localparam int DSH_BITS  = TIME_BITS + QUO_BITS - 1;
	localparam int CNT_BITS  = $clog2(QUO_BITS);
	localparam int ATT_BITS  = 15;

	localparam logic [VOL_BITS-1:0] VOL_FULL = VOL_BITS'(100);

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_PLAY = 2'd1,
		REQ_STOP = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		PH_STOP    = 3'd0,
		PH_DELAY   = 3'd1,
		PH_FADEIN  = 3'd2,
		PH_PLAY    = 3'd3,
		PH_FADEOUT = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} seq_st_t;

	typedef enum logic [1:0] {
		CFG_MAX_VOLUME  = 2'd0,
		CFG_LOOP_ENABLE = 2'd1,
		CFG_IS_3D       = 2'd2
	} cfg_idx_t;

	// trunc(3000 * log10(v / 100)), floor at -10000 for silence
	localparam int ATTEN_LUT [101] = '{
		-10000, -6000, -5096, -4568, -4193, -3903, -3665, -3464, -3290, -3137,
		-3000, -2875, -2762, -2658, -2561, -2471, -2387, -2308, -2234, -2163,
		-2096, -2033, -1972, -1914, -1859, -1806, -1755, -1705, -1658, -1612,
		-1568, -1525, -1484, -1444, -1405, -1367, -1331, -1295, -1260, -1226,
		-1193, -1161, -1130, -1099, -1069, -1040, -1011, -983, -956, -929,
		-903, -877, -851, -827, -802, -778, -755, -732, -709, -687,
		-665, -644, -622, -601, -581, -561, -541, -521, -502, -483,
		-464, -446, -428, -410, -392, -374, -357, -340, -323, -307,
		-290, -274, -258, -242, -227, -211, -196, -181, -166, -151,
		-137, -122, -108, -94, -80, -66, -53, -39, -26, -13,
		0
	};

	function automatic logic signed [ATT_BITS-1:0] atten_lookup(input logic [VOL_BITS-1:0] v);
		logic signed [ATT_BITS-1:0] r;
		if (v > VOL_FULL) begin
			r = '0;
		end else begin
			r = ATT_BITS'(ATTEN_LUT[v]);
		end
		return r;
	endfunction

endpackage

[rtl/sound_fade_envelope_sequencer.sv]
`timescale 1ns / 1ps

// Sound fade envelope sequencer: steps one voice through stop, start delay, fade-in,
// play and fade-out on tick, play and stop beats, and returns one result beat for every
// input beat. Play and stop requests, and ticks in stop, go from idle to the output
// state; other ticks pass an evaluate state first, and one that lands inside a fade
// computes acc * vol / fade_time (fade_time - acc in place of acc on fade-out) with a
// shift-add multiplier that takes one volume bit per cycle followed by a restoring divider
// that yields one quotient bit per cycle. A new beat is taken once the previous one has
// moved into the output register, which holds it until the downstream side takes it.
module sound_fade_envelope_sequencer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [sfes_pkg::VOL_BITS-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            req_type,
	input  logic [sfes_pkg::TIME_BITS-1:0]        elapsed_time,
	input  logic [sfes_pkg::TIME_BITS-1:0]        start_delay,
	input  logic [sfes_pkg::TIME_BITS-1:0]        fade_in_time,
	input  logic                                  immediate,
	input  logic [sfes_pkg::TIME_BITS-1:0]        fade_out_time,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [2:0]                            play_state,
	output logic                                  volume_write,
	output logic [sfes_pkg::VOL_BITS-1:0]         volume_percent,
	output logic signed [sfes_pkg::ATT_BITS-1:0]  attenuation,
	output logic                                  start_playback,
	output logic                                  stop_playback
);
	import sfes_pkg::*;

	seq_st_t state_q, state_d;
	phase_t  phase_q;

	logic [ACC_BITS-1:0]  acc_q;
	logic [TIME_BITS-1:0] fade_in_q, fade_out_q, delay_q;
	logic [VOL_BITS-1:0]  max_volume_q;
	logic                 loop_q, is3d_q;

	logic [TIME_BITS-1:0] mcand_q;
	logic [VOL_BITS-1:0]  mplr_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [DSH_BITS-1:0]  dsh_q;
	logic [QUO_BITS-1:0]  quo_q;
	logic [CNT_BITS-1:0]  cnt_q;

	logic                res_wr_q, res_start_q, res_stop_q;
	logic [VOL_BITS-1:0] res_vol_q;

	logic                       out_valid_q;
	logic [2:0]                 play_state_q;
	logic                       volume_write_q;
	logic [VOL_BITS-1:0]        volume_percent_q;
	logic signed [ATT_BITS-1:0] attenuation_q;
	logic                       start_q, stop_q;

	logic [VOL_BITS-1:0]  full_vol;
	logic [ACC_BITS:0]    acc_sum;
	logic [ACC_BITS-1:0]  acc_sat;
	logic                 delay_done, fin_done, fout_done;
	logic [PROD_BITS-1:0] prod_next;
	logic                 div_ge;
	logic [PROD_BITS-1:0] div_diff;
	logic                 last_step;
	logic                 out_free;
	logic                 eval_div;
	logic                 active;

	assign full_vol   = (max_volume_q > VOL_FULL) ? VOL_FULL : max_volume_q;
	assign acc_sum    = {1'b0, acc_q} + (ACC_BITS + 1)'(elapsed_time);
	assign acc_sat    = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
	assign delay_done = acc_q >= ACC_BITS'(delay_q);
	assign fin_done   = acc_q >= ACC_BITS'(fade_in_q);
	assign fout_done  = acc_q >= ACC_BITS'(fade_out_q);
	assign prod_next  = {prod_q[PROD_BITS-2:0], 1'b0}
		+ (mplr_q[VOL_BITS-1] ? PROD_BITS'(mcand_q) : '0);
	assign div_ge     = prod_q >= PROD_BITS'(dsh_q);
	assign div_diff   = prod_q - PROD_BITS'(dsh_q);
	assign last_step  = cnt_q == CNT_BITS'(QUO_BITS - 1);
	assign out_free   = !out_valid_q || !out_stall;
	assign eval_div   = (phase_q == PH_FADEIN && !fin_done) || (phase_q == PH_FADEOUT && !fout_done);
	assign active     = phase_q == PH_DELAY || phase_q == PH_FADEIN || phase_q == PH_PLAY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (req_type == REQ_TICK && phase_q != PH_STOP) begin
						state_d = ST_EVAL;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_EVAL: begin
				state_d = eval_div ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				if (last_step) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (last_step) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// voice state, configuration and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_STOP;
			acc_q        <= '0;
			fade_in_q    <= '0;
			fade_out_q   <= '0;
			delay_q      <= '0;
			max_volume_q <= VOL_FULL;
			loop_q       <= 1'b0;
			is3d_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_VOLUME:  max_volume_q <= cfg_data;
					CFG_LOOP_ENABLE: loop_q <= cfg_data[0];
					CFG_IS_3D:       is3d_q <= cfg_data[0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (req_type)
							REQ_TICK: begin
								if (phase_q != PH_STOP) acc_q <= acc_sat;
							end
							REQ_PLAY: begin
								fade_in_q  <= fade_in_time;
								fade_out_q <= '0;
								delay_q    <= start_delay;
								acc_q      <= '0;
								phase_q    <= PH_DELAY;
							end
							REQ_STOP: begin
								if (active) begin
									acc_q      <= '0;
									fade_out_q <= fade_out_time;
									phase_q    <= (fade_out_time == '0) ? PH_STOP : PH_FADEOUT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_EVAL: begin
					case (phase_q)
						PH_DELAY: begin
							if (delay_done) begin
								acc_q <= '0;
								if (fade_in_q == '0) begin
									phase_q <= loop_q ? PH_PLAY : PH_STOP;
								end else begin
									phase_q <= PH_FADEIN;
								end
							end
						end
						PH_FADEIN: begin
							if (fin_done) begin
								acc_q   <= '0;
								phase_q <= loop_q ? PH_PLAY : PH_STOP;
							end
						end
						PH_PLAY: begin
							if (!loop_q) phase_q <= PH_STOP;
						end
						PH_FADEOUT: begin
							if (fout_done) begin
								acc_q   <= '0;
								phase_q <= PH_STOP;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase

			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result staging, multiply and divide datapath, output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_wr_q    <= 1'b0;
					res_vol_q   <= '0;
					res_start_q <= 1'b0;
					res_stop_q  <= 1'b0;
					if (req_type == REQ_PLAY) begin
						res_stop_q <= immediate && active;
					end else if (req_type == REQ_STOP) begin
						res_stop_q <= active && fade_out_time == '0;
					end
				end
			end
			ST_EVAL: begin
				cnt_q  <= '0;
				mplr_q <= full_vol;
				prod_q <= '0;
				case (phase_q)
					PH_DELAY: begin
						if (delay_done) begin
							res_start_q <= 1'b1;
							res_wr_q    <= !is3d_q;
							res_vol_q   <= (fade_in_q == '0 && !is3d_q) ? full_vol : '0;
						end
					end
					PH_FADEIN: begin
						if (fin_done) begin
							res_wr_q  <= !is3d_q;
							res_vol_q <= is3d_q ? '0 : full_vol;
						end else begin
							mcand_q <= acc_q[TIME_BITS-1:0];
							dsh_q   <= {fade_in_q, (QUO_BITS - 1)'(0)};
						end
					end
					PH_FADEOUT: begin
						if (fout_done) begin
							res_wr_q   <= !is3d_q;
							res_vol_q  <= '0;
							res_stop_q <= 1'b1;
						end else begin
							mcand_q <= fade_out_q - acc_q[TIME_BITS-1:0];
							dsh_q   <= {fade_out_q, (QUO_BITS - 1)'(0)};
						end
					end
					default: ;
				endcase
			end
			ST_MUL: begin
				prod_q <= prod_next;
				mplr_q <= {mplr_q[VOL_BITS-2:0], 1'b0};
				cnt_q  <= last_step ? '0 : cnt_q + 1'b1;
			end
			ST_DIV: begin
				if (div_ge) prod_q <= div_diff;
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[QUO_BITS-2:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					res_wr_q  <= !is3d_q;
					res_vol_q <= is3d_q ? '0 : {quo_q[QUO_BITS-2:0], div_ge};
				end
			end
			ST_OUT: begin
				if (out_free) begin
					play_state_q     <= phase_q;
					volume_write_q   <= res_wr_q;
					volume_percent_q <= res_vol_q;
					attenuation_q    <= res_wr_q ? atten_lookup(res_vol_q) : '0;
					start_q          <= res_start_q;
					stop_q           <= res_stop_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign play_state     = play_state_q;
	assign volume_write   = volume_write_q;
	assign volume_percent = volume_percent_q;
	assign attenuation    = attenuation_q;
	assign start_playback = start_q;
	assign stop_playback  = stop_q;

`ifndef SYNTH
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(start_playback && stop_playback))
		else $error("start and stop pulses in the same beat");

	a_quiet_vol: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !volume_write) |-> (volume_percent == '0 && attenuation == '0))
		else $error("volume fields set without a volume write");

	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> volume_percent <= VOL_FULL)
		else $error("volume above full scale");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> prod_q < {dsh_q, 1'b0})
		else $error("divider remainder out of range");
`endif

endmodule

[tb/tb_sound_fade_envelope_sequencer.sv]
`timescale 1ns / 1ps

module tb_sound_fade_envelope_sequencer;
	import sfes_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [23:0] T_MAX = 24'hFF_FFFF;

	// hundredths of a dB per volume percent, -10000 for silence
	localparam int MB_ATTEN [101] = '{
		-10000, -6000, -5096, -4568, -4193, -3903, -3665, -3464, -3290, -3137,
		-3000, -2875, -2762, -2658, -2561, -2471, -2387, -2308, -2234, -2163,
		-2096, -2033, -1972, -1914, -1859, -1806, -1755, -1705, -1658, -1612,
		-1568, -1525, -1484, -1444, -1405, -1367, -1331, -1295, -1260, -1226,
		-1193, -1161, -1130, -1099, -1069, -1040, -1011, -983, -956, -929,
		-903, -877, -851, -827, -802, -778, -755, -732, -709, -687,
		-665, -644, -622, -601, -581, -561, -541, -521, -502, -483,
		-464, -446, -428, -410, -392, -374, -357, -340, -323, -307,
		-290, -274, -258, -242, -227, -211, -196, -181, -166, -151,
		-137, -122, -108, -94, -80, -66, -53, -39, -26, -13,
		0
	};

	typedef struct packed {
		logic [1:0]  req;
		logic [23:0] elapsed;
		logic [23:0] delay_us;
		logic [23:0] fade_in_us;
		logic        imm;
		logic [23:0] fade_out_us;
	} voice_req_s;

	typedef struct packed {
		logic [2:0]         state;
		logic               vol_wr;
		logic [6:0]         vol;
		logic signed [14:0] atten;
		logic               start_p;
		logic               stop_p;
	} voice_res_s;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_MAX_VOLUME;
	logic [VOL_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_TICK;
	logic [TIME_BITS-1:0] elapsed_time = '0;
	logic [TIME_BITS-1:0] start_delay = '0;
	logic [TIME_BITS-1:0] fade_in_time = '0;
	logic immediate = 1'b0;
	logic [TIME_BITS-1:0] fade_out_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] play_state;
	logic volume_write;
	logic [VOL_BITS-1:0] volume_percent;
	logic signed [ATT_BITS-1:0] attenuation;
	logic start_playback;
	logic stop_playback;

	sound_fade_envelope_sequencer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.elapsed_time   (elapsed_time),
		.start_delay    (start_delay),
		.fade_in_time   (fade_in_time),
		.immediate      (immediate),
		.fade_out_time  (fade_out_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.play_state     (play_state),
		.volume_write   (volume_write),
		.volume_percent (volume_percent),
		.attenuation    (attenuation),
		.start_playback (start_playback),
		.stop_playback  (stop_playback)
	);

	// voice state and register copies
	phase_t      v_phase = PH_STOP;
	logic [31:0] v_acc = '0;
	logic [23:0] v_fade_in = '0;
	logic [23:0] v_fade_out = '0;
	logic [23:0] v_delay = '0;
	logic [6:0]  m_max_vol = 7'd100;
	logic        m_loop = 1'b0;
	logic        m_3d = 1'b0;

	voice_req_s  pending_reqs [$];
	voice_res_s  expected_res [$];
	voice_req_s  next_req;
	voice_req_s  taken_req;
	voice_res_s  want;
	logic        beat_taken = 1'b0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          n_queued = 0;
	int          n_checked = 0;
	int          n_errors = 0;
	int          n_starts = 0;
	int          n_stops = 0;
	int          n_vol_writes = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic halt_voice(input logic [23:0] fade);
		if (v_phase == PH_FADEOUT || v_phase == PH_STOP)
			return 1'b0;
		v_acc = '0;
		v_fade_out = fade;
		if (fade == '0) begin
			v_phase = PH_STOP;
			return 1'b1;
		end
		v_phase = PH_FADEOUT;
		return 1'b0;
	endfunction

	function automatic voice_res_s envelope_step(input voice_req_s r);
		voice_res_s res;
		logic [32:0] sum;
		logic [63:0] num;
		logic [6:0]  full;
		logic        wr;
		logic [6:0]  vol;
		res = '0;
		wr = 1'b0;
		vol = '0;
		full = (m_max_vol > 7'd100) ? 7'd100 : m_max_vol;
		if (r.req == REQ_TICK && v_phase != PH_STOP) begin
			sum = {1'b0, v_acc} + 33'(r.elapsed);
			v_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			if (v_phase == PH_DELAY && v_acc >= 32'(v_delay)) begin
				v_acc = '0;
				v_phase = PH_FADEIN;
				res.start_p = 1'b1;
			end
			if (v_phase == PH_FADEIN) begin
				wr = 1'b1;
				if (v_acc >= 32'(v_fade_in)) begin
					v_acc = '0;
					v_phase = PH_PLAY;
					vol = full;
				end else begin
					num = 64'(v_acc) * 64'(full);
					vol = 7'(num / 64'(v_fade_in));
				end
			end
			if (v_phase == PH_PLAY && !m_loop)
				v_phase = PH_STOP;
			if (v_phase == PH_FADEOUT) begin
				wr = 1'b1;
				if (v_acc >= 32'(v_fade_out)) begin
					v_acc = '0;
					v_phase = PH_STOP;
					vol = '0;
					res.stop_p = 1'b1;
				end else begin
					num = (64'(v_fade_out) - 64'(v_acc)) * 64'(full);
					vol = 7'(num / 64'(v_fade_out));
				end
			end
		end else if (r.req == REQ_PLAY) begin
			if (r.imm)
				res.stop_p = halt_voice('0);
			v_fade_in = r.fade_in_us;
			v_fade_out = '0;
			v_delay = r.delay_us;
			v_acc = '0;
			v_phase = PH_DELAY;
		end else if (r.req == REQ_STOP) begin
			res.stop_p = halt_voice(r.fade_out_us);
		end
		// a positional voice never takes a volume
		if (m_3d) begin
			wr = 1'b0;
			vol = '0;
		end
		res.state = v_phase;
		res.vol_wr = wr;
		res.vol = vol;
		res.atten = wr ? 15'(MB_ATTEN[vol]) : '0;
		return res;
	endfunction

	task automatic check_field(input string fname, input logic signed [31:0] exp_v,
			input logic signed [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", fname, exp_v, act_v);
			n_errors++;
		end
	endtask

	// drive request beats; hold the payload until it is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || beat_taken)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				req_type <= next_req.req;
				elapsed_time <= next_req.elapsed;
				start_delay <= next_req.delay_us;
				fade_in_time <= next_req.fade_in_us;
				immediate <= next_req.imm;
				fade_out_time <= next_req.fade_out_us;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		beat_taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			taken_req.req = req_type;
			taken_req.elapsed = elapsed_time;
			taken_req.delay_us = start_delay;
			taken_req.fade_in_us = fade_in_time;
			taken_req.imm = immediate;
			taken_req.fade_out_us = fade_out_time;
			expected_res.push_back(envelope_step(taken_req));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_res.size() == 0) begin
				$error("result beat with no request outstanding");
				n_errors++;
			end else begin
				want = expected_res.pop_front();
				n_checked++;
				check_field("play_state", want.state, play_state);
				check_field("volume_write", want.vol_wr, volume_write);
				check_field("volume_percent", want.vol, volume_percent);
				check_field("attenuation", want.atten, attenuation);
				check_field("start_playback", want.start_p, start_playback);
				check_field("stop_playback", want.stop_p, stop_playback);
				n_starts += int'(start_playback);
				n_stops += int'(stop_playback);
				n_vol_writes += int'(volume_write);
			end
		end
	end

	function automatic voice_req_s noise_req();
		voice_req_s it;
		it.req = 2'($urandom_range(3));
		it.elapsed = 24'($urandom);
		it.delay_us = 24'($urandom);
		it.fade_in_us = 24'($urandom);
		it.imm = 1'($urandom_range(1));
		it.fade_out_us = 24'($urandom);
		return it;
	endfunction

	// mostly short spans so sequences walk the phases; now and then full range
	function automatic logic [23:0] pick_time(input int unsigned lim);
		if ($urandom_range(15) == 0)
			return 24'($urandom);
		return 24'($urandom_range(lim));
	endfunction

	task automatic push_req(input voice_req_s it);
		pending_reqs.push_back(it);
		n_queued++;
	endtask

	task automatic push_tick(input logic [23:0] el);
		voice_req_s it;
		it = noise_req();
		it.req = REQ_TICK;
		it.elapsed = el;
		push_req(it);
	endtask

	task automatic push_play(input logic [23:0] dly, input logic [23:0] fin, input logic imm);
		voice_req_s it;
		it = noise_req();
		it.req = REQ_PLAY;
		it.delay_us = dly;
		it.fade_in_us = fin;
		it.imm = imm;
		push_req(it);
	endtask

	task automatic push_stop(input logic [23:0] fout);
		voice_req_s it;
		it = noise_req();
		it.req = REQ_STOP;
		it.fade_out_us = fout;
		push_req(it);
	endtask

	task automatic push_voice_sequence();
		voice_req_s it;
		int unsigned k;
		if ($urandom_range(99) < 80) begin
			push_play(($urandom_range(3) == 0) ? '0 : pick_time(2000),
				($urandom_range(3) == 0) ? '0 : pick_time(4000), 1'($urandom_range(1)));
			k = $urandom_range(8, 1);
			repeat (k) push_tick(pick_time(1200));
			if ($urandom_range(1)) begin
				push_stop(($urandom_range(4) == 0) ? '0 : pick_time(3000));
				k = $urandom_range(6, 1);
				repeat (k) push_tick(pick_time(1200));
			end
		end else begin
			k = $urandom_range(4, 1);
			repeat (k) begin
				it = noise_req();
				push_req(it);
			end
		end
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [6:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_MAX_VOLUME: m_max_vol = val;
			CFG_LOOP_ENABLE: m_loop = val[0];
			CFG_IS_3D: m_3d = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (n_checked != n_queued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		voice_req_s it;
		int start_cnt;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: full volume, no loop, 2D
		push_tick(T_MAX);
		it = noise_req();
		it.req = REQ_UNUSED;
		push_req(it);
		push_stop(24'd100);
		push_play('0, '0, 1'b0);
		push_tick('0);
		push_play(24'd100, 24'd1000, 1'b1);
		push_tick(24'd50);
		push_tick(24'd50);
		push_tick(24'd333);
		push_tick(T_MAX);
		push_play('0, T_MAX, 1'b0);
		push_tick(24'd1);
		push_tick(T_MAX - 24'd1);
		push_stop(T_MAX);
		push_stop(24'd5);
		push_tick(24'd1);
		push_tick(T_MAX);
		push_play(24'd10, '0, 1'b0);
		push_play(24'd10, 24'd100, 1'b1);
		push_stop('0);
		wait_drained();

		cfg_write(CFG_MAX_VOLUME, 7'd127);
		cfg_write(CFG_LOOP_ENABLE, 7'd1);
		push_play('0, '0, 1'b0);
		push_tick(24'd5);
		push_play('0, 24'd200, 1'b1);
		push_tick('0);
		push_tick(24'd150);
		push_tick(24'd50);
		// park in looped play long enough to pin the accumulator
		repeat (270) push_tick(T_MAX);
		push_stop(24'd200);
		push_tick(24'd100);
		push_tick(24'd100);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					cfg_write(CFG_MAX_VOLUME, 7'd100);
					cfg_write(CFG_LOOP_ENABLE, 7'd0);
					cfg_write(CFG_IS_3D, 7'd0);
				end
				1: begin
					send_idle_pct = 50;
					stall_pct = 0;
					cfg_write(CFG_MAX_VOLUME, 7'd0);
					cfg_write(CFG_LOOP_ENABLE, 7'd1);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 50;
					cfg_write(CFG_MAX_VOLUME, 7'($urandom_range(99, 1)));
					cfg_write(CFG_LOOP_ENABLE, 7'd0);
					cfg_write(CFG_IS_3D, 7'd1);
				end
				default: begin
					send_idle_pct = 12;
					stall_pct = 12;
					cfg_write(CFG_MAX_VOLUME, 7'd101);
					cfg_write(CFG_LOOP_ENABLE, 7'd1);
					cfg_write(CFG_IS_3D, 7'd0);
				end
			endcase
			start_cnt = n_queued;
			while (n_queued - start_cnt < 100)
				push_voice_sequence();
			wait_drained();
		end

		repeat (40) @(negedge clk);
		if (expected_res.size() != 0) begin
			$error("%0d result beats never arrived", expected_res.size());
			n_errors++;
		end
		$display("summary: %0d request beats checked over four pacing mixes and six register sets",
			n_checked);
		$display("summary: %0d start pulses, %0d stop pulses, %0d volume writes seen",
			n_starts, n_stops, n_vol_writes);
		if (n_errors == 0)
			$display("tb_sound_fade_envelope_sequencer: done, clean");
		else
			$display("tb_sound_fade_envelope_sequencer: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d of %0d beats checked", n_checked, n_queued);
		$display("tb_sound_fade_envelope_sequencer: done, errors");
		$finish;
	end

endmodule
